// ===== hw/rtl/hmit_pkg.sv =====
package hmit_pkg;

	// Default table depth.
	localparam int MAX_INTERFACES_DEF = 4;

	// Command codes of an input transaction.
	typedef enum logic [1:0] {
		CMD_DESC    = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_REPORT  = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	// Report descriptor items that open a media collection.
	localparam logic [7:0] TAG_USAGE_PAGE   = 8'h05;
	localparam logic [7:0] TAG_USAGE        = 8'h09;
	localparam logic [7:0] PAGE_CONSUMER    = 8'h0C;
	localparam logic [7:0] PAGE_GENERIC     = 8'h01;
	localparam logic [7:0] USAGE_CONSUMER   = 8'h01;
	localparam logic [7:0] USAGE_SYSTEM     = 8'h80;

	// Report identifiers and length thresholds.
	localparam logic [7:0] RID_CONSUMER     = 8'h01;
	localparam logic [7:0] RID_SYSTEM       = 8'h02;
	localparam logic [1:0] LEN_SYSTEM_MIN   = 2'd2;
	localparam logic [1:0] LEN_CONSUMER_MIN = 2'd3;

	typedef struct packed {
		cmd_t        command;
		logic [7:0]  usb_addr;
		logic [7:0]  instance_req;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [1:0]  report_len;
		logic        last_byte;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] usage;
		logic [7:0]  system_bits;
		logic [2:0]  used_count;
	} result_t;

	// Control broadcast from the top level to every table cell.
	typedef struct packed {
		logic        add;
		logic        rel;
		logic [7:0]  dev;
		logic [7:0]  inst;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/hmit_scan.sv =====
module hmit_scan (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] data,
	input  logic       last,
	output logic       found
);

	logic [23:0] window_q;
	logic [1:0]  seen_q;
	logic        found_q;
	logic        hit_consumer;
	logic        hit_system;

	// Oldest byte sits in the top of the window.
	always_comb begin
		hit_consumer = (window_q[23:16] == hmit_pkg::TAG_USAGE_PAGE)
			&& (window_q[15:8] == hmit_pkg::PAGE_CONSUMER)
			&& (window_q[7:0] == hmit_pkg::TAG_USAGE)
			&& (data == hmit_pkg::USAGE_CONSUMER);
		hit_system = (window_q[23:16] == hmit_pkg::TAG_USAGE_PAGE)
			&& (window_q[15:8] == hmit_pkg::PAGE_GENERIC)
			&& (window_q[7:0] == hmit_pkg::TAG_USAGE)
			&& (data == hmit_pkg::USAGE_SYSTEM);
		found = found_q || ((seen_q == 2'd3) && (hit_consumer || hit_system));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
			found_q  <= 1'b0;
		end else if (en) begin
			if (last) begin
				window_q <= '0;
				seen_q   <= '0;
				found_q  <= 1'b0;
			end else begin
				window_q <= {window_q[15:0], data};
				if (seen_q != 2'd3) begin
					seen_q <= seen_q + 2'd1;
				end
				found_q <= found;
			end
		end
	end

endmodule

// ===== hw/rtl/hmit_cell.sv =====
module hmit_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 3
) (
	input  logic                  clk,
	input  hmit_pkg::cell_ctl_t   ctl,
	input  logic [CNT_W-1:0]      used,
	input  logic [7:0]            nb_dev,
	input  logic [7:0]            nb_inst,
	input  logic                  hit_in,
	output logic                  hit_out,
	output logic [7:0]            dev_q,
	output logic [7:0]            inst_q
);

	logic occupied;
	logic match;

	always_comb begin
		occupied = CNT_W'(INDEX) < used;
		match    = occupied && (dev_q == ctl.dev) && (inst_q == ctl.inst);
		hit_out  = hit_in || match;
	end

	// A new entry lands in the first free cell; on release every cell at or
	// after the first match takes its right-hand neighbour's contents.
	always_ff @(posedge clk) begin
		if (ctl.add && (used == CNT_W'(INDEX))) begin
			dev_q  <= ctl.dev;
			inst_q <= ctl.inst;
		end else if (ctl.rel && hit_out) begin
			dev_q  <= nb_dev;
			inst_q <= nb_inst;
		end
	end

endmodule

// ===== hw/rtl/hid_media_interface_table_unit.sv =====
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   item   (hmit_pkg::item_t)
// result    out        done high, one cycle   result (hmit_pkg::result_t)
//
// Each transaction is taken whenever start is high; its result appears on
// the next cycle with done high, so one transaction per cycle is sustained.
// The figure is set by the table cells, which all compare and shift in the
// same cycle, and by the descriptor window, which moves one byte a cycle.
// Reset clears the window, the entry count and the held key values; the
// table contents are not reset; a claim or a release writes them.
// The receiver cannot stall, so busy stays low.
module hid_media_interface_table_unit #(
	parameter int MAX_INTERFACES = hmit_pkg::MAX_INTERFACES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hmit_pkg::item_t   item,
	output logic              done,
	output hmit_pkg::result_t result
);

	localparam int CNT_W = $clog2(MAX_INTERFACES + 1);

	logic                take;
	logic                is_desc;
	logic                is_rel;
	logic                is_rep;
	logic                is_read;
	logic                found;
	logic                room;
	logic                add;
	logic                any_hit;
	logic [CNT_W-1:0]    used_q;
	logic [CNT_W-1:0]    used_next;
	logic [15:0]         held_usage_q;
	logic [7:0]          held_system_q;
	logic                done_q;
	hmit_pkg::result_t   result_q;
	hmit_pkg::result_t   result_next;
	hmit_pkg::cell_ctl_t ctl;

	logic [MAX_INTERFACES:0] hit_chain;
	logic [7:0]              cell_dev  [MAX_INTERFACES];
	logic [7:0]              cell_inst [MAX_INTERFACES];

	assign busy = 1'b0;
	assign take = start && !busy;

	always_comb begin
		is_desc = take && (item.command == hmit_pkg::CMD_DESC);
		is_rel  = take && (item.command == hmit_pkg::CMD_RELEASE);
		is_rep  = take && (item.command == hmit_pkg::CMD_REPORT);
		is_read = take && (item.command == hmit_pkg::CMD_READ);
	end

	// The descriptor window watches for a media collection during a claim.
	hmit_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (is_desc),
		.data   (item.byte0),
		.last   (item.last_byte),
		.found  (found)
	);

	assign room = used_q < CNT_W'(MAX_INTERFACES);
	assign add  = is_desc && item.last_byte && found && room;

	always_comb begin
		ctl.add  = add;
		ctl.rel  = is_rel;
		ctl.dev  = item.usb_addr;
		ctl.inst = item.instance_req;
	end

	// The table is a row of cells. The hit chain runs left to right and tells
	// each cell whether the key was found in it or in any cell to its left.
	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < MAX_INTERFACES; i++) begin : g_cell
		logic [7:0] nb_dev;
		logic [7:0] nb_inst;

		if (i < MAX_INTERFACES - 1) begin : g_mid
			assign nb_dev  = cell_dev[i+1];
			assign nb_inst = cell_inst[i+1];
		end else begin : g_end
			// The last cell falls out of use on a release, so its contents do
			// not matter.
			assign nb_dev  = cell_dev[i];
			assign nb_inst = cell_inst[i];
		end

		hmit_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.used    (used_q),
			.nb_dev  (nb_dev),
			.nb_inst (nb_inst),
			.hit_in  (hit_chain[i]),
			.hit_out (hit_chain[i+1]),
			.dev_q   (cell_dev[i]),
			.inst_q  (cell_inst[i])
		);
	end

	assign any_hit = hit_chain[MAX_INTERFACES];

	always_comb begin
		used_next = used_q;
		if (add) begin
			used_next = used_q + CNT_W'(1);
		end else if (is_rel && any_hit) begin
			used_next = used_q - CNT_W'(1);
		end
	end

	always_comb begin
		result_next             = '0;
		result_next.accepted    = add || (is_rep && any_hit);
		result_next.used_count  = 3'(used_next);
		if (is_read) begin
			result_next.usage       = held_usage_q;
			result_next.system_bits = held_system_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q        <= '0;
			held_usage_q  <= '0;
			held_system_q <= '0;
			done_q        <= 1'b0;
		end else begin
			used_q <= used_next;
			done_q <= take;
			if (is_read) begin
				held_usage_q  <= '0;
				held_system_q <= '0;
			end else if (is_rep && any_hit) begin
				// A zero value leaves the held key as it was.
				if ((item.byte0 == hmit_pkg::RID_CONSUMER)
						&& (item.report_len >= hmit_pkg::LEN_CONSUMER_MIN)) begin
					if ({item.byte2, item.byte1} != 16'd0) begin
						held_usage_q <= {item.byte2, item.byte1};
					end
				end else if ((item.byte0 == hmit_pkg::RID_SYSTEM)
						&& (item.report_len >= hmit_pkg::LEN_SYSTEM_MIN)) begin
					if (item.byte1 != 8'd0) begin
						held_system_q <= item.byte1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= result_next;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// The entry count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(MAX_INTERFACES))
		else $error("entry count beyond table depth");

	// Every transaction taken gives exactly one result on the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> done)
		else $error("result missing after transaction");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> !done)
		else $error("result without transaction");

	// The entry count holds while no transaction is taken.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(used_q))
		else $error("entry count changed while idle");

	// A refused claim on a full table leaves the table full.
	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(is_desc && !room) |-> !add)
		else $error("entry added to a full table");

endmodule

// ===== dv/hmit_media_checker.sv =====
module hmit_media_checker
	import hmit_pkg::*;
#(
	parameter int MAX_INTERFACES = MAX_INTERFACES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  item_t       item,
	input  logic        done,
	input  result_t     result,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	// Shadow copy of the block state.
	logic [23:0] desc_window;
	logic [1:0]  desc_count;
	logic        collection_seen;
	logic [7:0]  claim_dev [MAX_INTERFACES];
	logic [7:0]  claim_inst [MAX_INTERFACES];
	int unsigned claims_used;
	logic [15:0] kept_usage;
	logic [7:0]  kept_system;

	result_t     pending_results [$];

	initial mismatches = 0;
	initial outstanding = 0;

	task automatic check_field(input string name, input logic [15:0] expv,
			input logic [15:0] actv);
		if (actv !== expv) begin
			$display("%0t: %s expected %h, got %h", $time, name, expv, actv);
			mismatches++;
		end
	endtask

	task automatic step_media_table(input item_t it, output result_t res);
		int unsigned i;
		int unsigned idx;
		logic        hit;
		res = '0;
		hit = 1'b0;
		idx = 0;
		case (it.command)
			CMD_DESC: begin
				if (desc_count == 2'd3) begin
					if (desc_window == {TAG_USAGE_PAGE, PAGE_CONSUMER, TAG_USAGE} &&
							it.byte0 == USAGE_CONSUMER)
						collection_seen = 1'b1;
					if (desc_window == {TAG_USAGE_PAGE, PAGE_GENERIC, TAG_USAGE} &&
							it.byte0 == USAGE_SYSTEM)
						collection_seen = 1'b1;
				end
				desc_window = {desc_window[15:0], it.byte0};
				if (desc_count != 2'd3)
					desc_count++;
				if (it.last_byte) begin
					if (collection_seen && claims_used < MAX_INTERFACES) begin
						claim_dev[claims_used] = it.usb_addr;
						claim_inst[claims_used] = it.instance_req;
						claims_used++;
						res.accepted = 1'b1;
					end
					desc_window = '0;
					desc_count = '0;
					collection_seen = 1'b0;
				end
			end
			CMD_RELEASE: begin
				for (i = 0; i < claims_used; i++) begin
					if (!hit && claim_dev[i] == it.usb_addr &&
							claim_inst[i] == it.instance_req) begin
						hit = 1'b1;
						idx = i;
					end
				end
				if (hit) begin
					for (i = idx; i + 1 < claims_used; i++) begin
						claim_dev[i] = claim_dev[i + 1];
						claim_inst[i] = claim_inst[i + 1];
					end
					claims_used--;
				end
			end
			CMD_REPORT: begin
				for (i = 0; i < claims_used; i++)
					if (claim_dev[i] == it.usb_addr && claim_inst[i] == it.instance_req)
						hit = 1'b1;
				if (hit) begin
					res.accepted = 1'b1;
					if (it.report_len >= LEN_SYSTEM_MIN) begin
						if (it.byte0 == RID_CONSUMER && it.report_len >= LEN_CONSUMER_MIN) begin
							if ({it.byte2, it.byte1} != 16'd0)
								kept_usage = {it.byte2, it.byte1};
						end else if (it.byte0 == RID_SYSTEM) begin
							if (it.byte1 != 8'd0)
								kept_system = it.byte1;
						end
					end
				end
			end
			default: begin
				res.usage = kept_usage;
				res.system_bits = kept_system;
				kept_usage = '0;
				kept_system = '0;
			end
		endcase
		res.used_count = 3'(claims_used);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t expv;
		result_t predicted;
		if (!arst_n) begin
			desc_window = '0;
			desc_count = '0;
			collection_seen = 1'b0;
			claims_used = 0;
			kept_usage = '0;
			kept_system = '0;
			pending_results.delete();
		end else begin
			// The result of the previous transaction is retired before the
			// transaction taken at this edge is predicted.
			if (done) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result expected none, got %h", $time, result);
					mismatches++;
				end else begin
					expv = pending_results.pop_front();
					check_field("accepted", 16'(expv.accepted), 16'(result.accepted));
					check_field("usage", expv.usage, result.usage);
					check_field("system_bits", 16'(expv.system_bits), 16'(result.system_bits));
					check_field("used_count", 16'(expv.used_count), 16'(result.used_count));
				end
			end
			if (start && !busy) begin
				step_media_table(item, predicted);
				pending_results.push_back(predicted);
			end
		end
		outstanding = pending_results.size();
	end

endmodule

// ===== dv/hid_media_interface_table_unit_tb.sv =====
module hid_media_interface_table_unit_tb;
	import hmit_pkg::*;

	// Addresses that the random part keeps coming back to, so that reports
	// and releases often find a claimed interface. The values also toggle
	// every bit of the address fields between them.
	localparam logic [7:0] ADDR_POOL [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
	localparam int unsigned ITEM_TARGET = 1150;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	item_t       item;
	result_t     result;
	int unsigned mismatches;
	int unsigned outstanding;

	// Stimulus bookkeeping only: how many transactions have gone in, the
	// largest gap currently drawn before each one, and the interfaces most
	// recently claimed.
	int unsigned items_sent;
	int unsigned gap_limit;
	logic [15:0] claimed_pairs [4];
	int unsigned claim_slot;

	hid_media_interface_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	hmit_media_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop in case the block stops taking transactions or stops
	// answering. A correct run with the longest gaps needs well under a
	// fifth of this.
	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [7:0] pick_addr();
		if ($urandom_range(0, 99) < 85)
			return ADDR_POOL[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	// Drives one transaction. A gap of idle cycles is drawn first; then
	// start is raised and held until the block takes the transaction. Busy
	// is looked at on the falling edge, where it is stable, so acceptance is
	// known to happen at the following rising edge. The task returns on that
	// edge, which leaves start high for a back-to-back transaction.
	task automatic send_item(input cmd_t cmd, input logic [7:0] dev, input logic [7:0] inst,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
			input logic [1:0] len, input logic last);
		int unsigned gap;
		gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= '{command: cmd, usb_addr: dev, instance_req: inst, byte0: b0, byte1: b1,
			byte2: b2, report_len: len, last_byte: last};
		start <= 1'b1;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	initial begin
		logic [7:0]  seq [8];
		logic [7:0]  dev;
		logic [7:0]  inst;
		logic [7:0]  rid;
		logic [15:0] pair;
		logic        with_collection;
		logic        system_kind;
		logic        abandon;
		int unsigned n;
		int unsigned p;
		int unsigned k;
		int unsigned r;

		items_sent = 0;
		gap_limit = 10;
		claim_slot = 0;
		for (k = 0; k < 4; k++)
			claimed_pairs[k] = {ADDR_POOL[k], ADDR_POOL[3 - k]};

		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A read straight after reset must return nothing
		// held, and a report from an interface that was never claimed is
		// refused.
		send_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
		send_item(CMD_REPORT, 8'hFF, 8'hFF, RID_CONSUMER, 8'hFF, 8'hFF, 2'd3, 1'b0);
		// A consumer control collection claims interface 00/00 at the lowest
		// address, a system control collection claims FF/FF at the highest.
		send_item(CMD_DESC, 8'h00, 8'h00, TAG_USAGE_PAGE, 8'h00, 8'h00, 2'd0, 1'b0);
		send_item(CMD_DESC, 8'h00, 8'h00, PAGE_CONSUMER, 8'h00, 8'h00, 2'd0, 1'b0);
		send_item(CMD_DESC, 8'h00, 8'h00, TAG_USAGE, 8'h00, 8'h00, 2'd0, 1'b0);
		send_item(CMD_DESC, 8'h00, 8'h00, USAGE_CONSUMER, 8'h00, 8'h00, 2'd0, 1'b1);
		send_item(CMD_DESC, 8'hFF, 8'hFF, TAG_USAGE_PAGE, 8'hFF, 8'hFF, 2'd3, 1'b0);
		send_item(CMD_DESC, 8'hFF, 8'hFF, PAGE_GENERIC, 8'hFF, 8'hFF, 2'd3, 1'b0);
		send_item(CMD_DESC, 8'hFF, 8'hFF, TAG_USAGE, 8'hFF, 8'hFF, 2'd3, 1'b0);
		send_item(CMD_DESC, 8'hFF, 8'hFF, USAGE_SYSTEM, 8'hFF, 8'hFF, 2'd3, 1'b1);
		// A descriptor shorter than four bytes can never match.
		send_item(CMD_DESC, 8'h12, 8'h34, PAGE_CONSUMER, 8'h00, 8'h00, 2'd0, 1'b0);
		send_item(CMD_DESC, 8'h12, 8'h34, TAG_USAGE, 8'h00, 8'h00, 2'd0, 1'b0);
		send_item(CMD_DESC, 8'h12, 8'h34, USAGE_CONSUMER, 8'h00, 8'h00, 2'd0, 1'b1);
		// Reports: the largest usage, a consumer report too short to hold,
		// a report of no length, system bits, a zero usage that must leave
		// the held one alone, and an unknown report ID.
		send_item(CMD_REPORT, 8'h00, 8'h00, RID_CONSUMER, 8'hFF, 8'hFF, 2'd3, 1'b1);
		send_item(CMD_REPORT, 8'h00, 8'h00, RID_CONSUMER, 8'h11, 8'h22, 2'd2, 1'b0);
		send_item(CMD_REPORT, 8'hFF, 8'hFF, RID_SYSTEM, 8'h01, 8'h00, 2'd0, 1'b0);
		send_item(CMD_REPORT, 8'hFF, 8'hFF, RID_SYSTEM, 8'h07, 8'h00, 2'd2, 1'b0);
		send_item(CMD_REPORT, 8'h00, 8'h00, RID_CONSUMER, 8'h00, 8'h00, 2'd3, 1'b0);
		send_item(CMD_REPORT, 8'hFF, 8'hFF, 8'h80, 8'h33, 8'h44, 2'd3, 1'b0);
		// Read returns the held values and clears them; a second read sees
		// nothing.
		send_item(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1);
		send_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
		// Releasing an unknown interface changes nothing; releasing the
		// first entry closes the gap.
		send_item(CMD_RELEASE, 8'h12, 8'h34, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
		send_item(CMD_RELEASE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);

		// Random part. Most of it is well-formed claims with random filler,
		// reports and releases aimed at interfaces that were claimed, and
		// reads; the rest is whole random transactions. Idle gaps come in
		// stretches, with some stretches running back to back.
		while (items_sent < ITEM_TARGET) begin
			if (items_sent % 64 < 8)
				gap_limit = ($urandom_range(0, 2) == 0) ? 0 : 10;
			r = $urandom_range(0, 99);
			if (r < 35) begin
				n = $urandom_range(1, 8);
				dev = pick_addr();
				inst = pick_addr();
				with_collection = ($urandom_range(0, 9) < 7);
				system_kind = $urandom_range(0, 1);
				// A claim now and then is left without its final byte, so its
				// window runs on into the next claim.
				abandon = ($urandom_range(0, 9) == 0);
				for (k = 0; k < n; k++) begin
					case ($urandom_range(0, 7))
						0: seq[k] = TAG_USAGE_PAGE;
						1: seq[k] = PAGE_CONSUMER;
						2: seq[k] = TAG_USAGE;
						3: seq[k] = USAGE_SYSTEM;
						default: seq[k] = 8'($urandom_range(0, 255));
					endcase
				end
				if (with_collection && n >= 4) begin
					p = $urandom_range(0, n - 4);
					seq[p] = TAG_USAGE_PAGE;
					seq[p + 1] = system_kind ? PAGE_GENERIC : PAGE_CONSUMER;
					seq[p + 2] = TAG_USAGE;
					seq[p + 3] = system_kind ? USAGE_SYSTEM : USAGE_CONSUMER;
					if (!abandon) begin
						claimed_pairs[claim_slot] = {dev, inst};
						claim_slot = (claim_slot + 1) % 4;
					end
				end
				for (k = 0; k < n; k++)
					send_item(CMD_DESC, dev, inst, seq[k], 8'($urandom), 8'($urandom),
						2'($urandom), (k == n - 1) && !abandon);
			end else if (r < 75) begin
				if ($urandom_range(0, 9) < 7) begin
					pair = claimed_pairs[$urandom_range(0, 3)];
					dev = pair[15:8];
					inst = pair[7:0];
				end else begin
					dev = pick_addr();
					inst = pick_addr();
				end
				if (r < 60) begin
					case ($urandom_range(0, 4))
						0, 1: rid = RID_CONSUMER;
						2, 3: rid = RID_SYSTEM;
						default: rid = 8'($urandom_range(0, 255));
					endcase
					send_item(CMD_REPORT, dev, inst, rid,
						($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom),
						($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom),
						2'($urandom), 1'($urandom));
				end else begin
					send_item(CMD_RELEASE, dev, inst, 8'($urandom), 8'($urandom),
						8'($urandom), 2'($urandom), 1'($urandom));
				end
			end else if (r < 88) begin
				send_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 2'($urandom), 1'($urandom));
			end else begin
				send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom), 1'($urandom));
			end
		end

		// Drain: every expected result must arrive; after that the bench still
		// waits, so that any stray result has the chance to show up.
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
